// ----- src/prs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package prs_pkg;

  // Table sizing defaults
  localparam int NumSlotsDef  = 16;
  localparam int PrioWidthDef = 8;

  // Fixed field widths of the ports
  localparam int SlotW  = 4;
  localparam int InPrW  = 8;
  localparam int StateW = 2;
  localparam int CountW = 5;
  localparam int KindW  = 2;

  // Run state codes of a slot
  localparam logic [StateW-1:0] RS_READY   = 2'd0;
  localparam logic [StateW-1:0] RS_RUNNING = 2'd1;
  localparam logic [StateW-1:0] RS_BLOCKED = 2'd2;

  // What is running now
  localparam logic [KindW-1:0] KIND_NONE = 2'd0;
  localparam logic [KindW-1:0] KIND_SLOT = 2'd1;
  localparam logic [KindW-1:0] KIND_IDLE = 2'd2;

  // Operation codes of an input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCHED = 1'b1;

endpackage

`default_nettype wire

// ----- src/prs_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Slot table: priority and run state memories, one write and one registered
// read a cycle. Entries never written read back as their reset values.
module prs_table #(
  parameter int NUM_SLOTS  = prs_pkg::NumSlotsDef,
  parameter int PRIO_WIDTH = prs_pkg::PrioWidthDef,
  localparam int IdxW      = $clog2(NUM_SLOTS)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      wr_en_i,
  input  wire logic                      wr_prio_en_i,
  input  wire logic [IdxW-1:0]           wr_addr_i,
  input  wire logic [PRIO_WIDTH-1:0]     wr_prio_i,
  input  wire logic [prs_pkg::StateW-1:0] wr_state_i,
  input  wire logic                      rd_en_i,
  input  wire logic [IdxW-1:0]           rd_addr_i,
  output logic      [PRIO_WIDTH-1:0]     rd_prio_o,
  output logic      [prs_pkg::StateW-1:0] rd_state_o
);

  logic [PRIO_WIDTH-1:0]      prio_mem  [NUM_SLOTS];
  logic [prs_pkg::StateW-1:0] state_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       vld_q;
  logic [PRIO_WIDTH-1:0]      rd_prio_q;
  logic [prs_pkg::StateW-1:0] rd_state_q;
  logic                       rd_vld_q;

  // Mark an entry valid once a full write has loaded it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i && wr_prio_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      state_mem[wr_addr_i] <= wr_state_i;
      if (wr_prio_en_i) begin
        prio_mem[wr_addr_i] <= wr_prio_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_prio_q  <= prio_mem[rd_addr_i];
      rd_state_q <= state_mem[rd_addr_i];
      rd_vld_q   <= vld_q[rd_addr_i];
    end
  end

  assign rd_prio_o  = rd_vld_q ? rd_prio_q  : '0;
  assign rd_state_o = rd_vld_q ? rd_state_q : prs_pkg::RS_BLOCKED;

endmodule

`default_nettype wire

// ----- src/prs_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared compare unit: one slot a cycle against the best so far.
module prs_scan #(
  parameter int NUM_SLOTS  = prs_pkg::NumSlotsDef,
  parameter int PRIO_WIDTH = prs_pkg::PrioWidthDef,
  localparam int IdxW      = $clog2(NUM_SLOTS)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       en_i,
  input  wire logic [IdxW-1:0]            idx_i,
  input  wire logic [PRIO_WIDTH-1:0]      prio_i,
  input  wire logic [prs_pkg::StateW-1:0] state_i,
  output logic                            found_o,
  output logic      [IdxW-1:0]            best_o
);

  logic                  found_q, found_d;
  logic [IdxW-1:0]       best_q, best_d;
  logic [PRIO_WIDTH-1:0] best_prio_q, best_prio_d;
  logic                  take;

  // Strict less-than keeps the lowest index on a tie
  assign take = en_i && (state_i == prs_pkg::RS_READY) &&
                (!found_q || (prio_i < best_prio_q));

  always_comb begin
    found_d     = found_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    if (clear_i) begin
      found_d = 1'b0;
      best_d  = '0;
    end else if (take) begin
      found_d     = 1'b1;
      best_d      = idx_i;
      best_prio_d = prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '0;
    end else begin
      found_q <= found_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
  end

  assign found_o = found_q;
  assign best_o  = best_q;

endmodule

`default_nettype wire

// ----- src/priority_ready_scheduler.sv -----
// Fixed-priority ready scheduler.
// Input channel (in_valid_i / in_stall_o): each beat is either a slot write
// (operation 0: load priority and run state of one slot) or a scheduling pass
// (operation 1). Output channel (out_valid_o / out_stall_i): one beat per
// scheduling pass with the chosen slot, an idle flag and a switched flag.
// Configuration: cfg_we_i loads active_count from cfg_wdata_i; write it only
// while the block is idle.
// Sequence: a scheduling pass scans the first n slots, n = min(active_count,
// slots): the single table read port and one shared comparator visit one slot
// per cycle, the last compare settles and the scan is left, then the table is
// updated (demote, then promote) and the output register is loaded.
// in_stall_o stays high for the whole pass.
// Reset: every slot reads as blocked with priority zero, nothing running,
// active_count zero; no clearing pass is needed, valid bits cover the table.
// Receiver stall: the result beat holds in the output register and new beats
// are still taken; a later pass waits in its last cycle until the register
// frees up.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_scheduler #(
  parameter int NUM_SLOTS  = prs_pkg::NumSlotsDef,
  parameter int PRIO_WIDTH = prs_pkg::PrioWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [prs_pkg::CountW-1:0]  cfg_wdata_i,
  // input beats
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [prs_pkg::SlotW-1:0]   slot_i,
  input  wire logic [prs_pkg::InPrW-1:0]   prio_value_i,
  input  wire logic [prs_pkg::StateW-1:0]  run_state_i,
  // result beats
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [prs_pkg::SlotW-1:0]   chosen_slot_o,
  output logic                             idle_chosen_o,
  output logic                             switched_o
);

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam int CntW = $clog2(NUM_SLOTS + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_PROM = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [prs_pkg::CountW-1:0]  active_count_q;
  logic [CntW-1:0]             n_q, n_d;
  logic [CntW-1:0]             ptr_q, ptr_d;
  logic                        rd_pend_q;
  logic [IdxW-1:0]             rd_idx_q;
  logic [prs_pkg::KindW-1:0]   cur_kind_q, cur_kind_d;
  logic [IdxW-1:0]             cur_idx_q, cur_idx_d;
  logic [prs_pkg::SlotW-1:0]   res_slot_q;
  logic                        res_idle_q;
  logic                        res_sw_q;
  logic                        out_valid_q, out_valid_d;
  logic [prs_pkg::SlotW-1:0]   out_slot_q;
  logic                        out_idle_q;
  logic                        out_sw_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        issue;
  logic                        same_slot;
  logic                        keep_idle;
  logic                        do_switch;
  logic                        do_demote;
  logic                        slot_ok;

  logic                        tbl_wr_en;
  logic                        tbl_wr_prio_en;
  logic [IdxW-1:0]             tbl_wr_addr;
  logic [prs_pkg::StateW-1:0]  tbl_wr_state;
  logic [PRIO_WIDTH-1:0]       rd_prio;
  logic [prs_pkg::StateW-1:0]  rd_state;
  logic                        found;
  logic [IdxW-1:0]             best;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = (state_q == ST_SCAN) && (ptr_q < n_q);
  assign slot_ok    = int'(slot_i) < NUM_SLOTS;

  // Outcome of the pass, taken from the unit and the running context
  assign same_slot = found && (cur_kind_q == prs_pkg::KIND_SLOT) && (cur_idx_q == best);
  assign keep_idle = !found && (cur_kind_q == prs_pkg::KIND_IDLE);
  assign do_switch = !(same_slot || keep_idle);
  assign do_demote = do_switch && (cur_kind_q == prs_pkg::KIND_SLOT);

  // Clamp the count to the table size
  always_comb begin
    if (int'(active_count_q) > NUM_SLOTS) begin
      n_d = CntW'(NUM_SLOTS);
    end else begin
      n_d = CntW'(active_count_q);
    end
  end

  // Table write port: slot write, demote, promote
  always_comb begin
    tbl_wr_en      = 1'b0;
    tbl_wr_prio_en = 1'b0;
    tbl_wr_addr    = IdxW'(slot_i);
    tbl_wr_state   = run_state_i;
    unique case (state_q)
      ST_IDLE: begin
        tbl_wr_en      = in_acc && (operation_i == prs_pkg::OP_WRITE) && slot_ok;
        tbl_wr_prio_en = 1'b1;
      end
      ST_UPD: begin
        tbl_wr_en    = do_demote;
        tbl_wr_addr  = cur_idx_q;
        tbl_wr_state = prs_pkg::RS_READY;
      end
      ST_PROM: begin
        tbl_wr_en    = found && do_switch;
        tbl_wr_addr  = best;
        tbl_wr_state = prs_pkg::RS_RUNNING;
      end
      default: begin
        tbl_wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cur_kind_d = cur_kind_q;
    cur_idx_d  = cur_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == prs_pkg::OP_SCHED)) begin
          ptr_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ptr_d = ptr_q + CntW'(1);
        end else if (!rd_pend_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_PROM;
      end
      ST_PROM: begin
        if (do_switch) begin
          cur_kind_d = found ? prs_pkg::KIND_SLOT : prs_pkg::KIND_IDLE;
          cur_idx_d  = found ? best : '0;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load on a free slot, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_count_q <= '0;
      n_q            <= '0;
      ptr_q          <= '0;
      rd_pend_q      <= 1'b0;
      cur_kind_q     <= prs_pkg::KIND_NONE;
      cur_idx_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rd_pend_q   <= issue;
      cur_kind_q  <= cur_kind_d;
      cur_idx_q   <= cur_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_count_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        n_q <= n_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= ptr_q[IdxW-1:0];
    end
    if (state_q == ST_PROM) begin
      res_slot_q <= found ? prs_pkg::SlotW'(best) : '0;
      res_idle_q <= !found;
      res_sw_q   <= do_switch;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_slot_q <= res_slot_q;
      out_idle_q <= res_idle_q;
      out_sw_q   <= res_sw_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_slot_o = out_slot_q;
  assign idle_chosen_o = out_idle_q;
  assign switched_o    = out_sw_q;

  prs_table #(
    .NUM_SLOTS  (NUM_SLOTS),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (tbl_wr_en),
    .wr_prio_en_i (tbl_wr_prio_en),
    .wr_addr_i    (tbl_wr_addr),
    .wr_prio_i    (PRIO_WIDTH'(prio_value_i)),
    .wr_state_i   (tbl_wr_state),
    .rd_en_i      (issue),
    .rd_addr_i    (ptr_q[IdxW-1:0]),
    .rd_prio_o    (rd_prio),
    .rd_state_o   (rd_state)
  );

  prs_scan #(
    .NUM_SLOTS  (NUM_SLOTS),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (in_acc && (operation_i == prs_pkg::OP_SCHED)),
    .en_i    (rd_pend_q),
    .idx_i   (rd_idx_q),
    .prio_i  (rd_prio),
    .state_i (rd_state),
    .found_o (found),
    .best_o  (best)
  );

  // The table is left alone while the scan reads it
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !tbl_wr_en)
    else $error("table written during scan");

  // A pick always lies inside the scanned range
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPD) && found) |-> (CntW'(best) < n_q))
    else $error("pick outside active range");

  // Idle context carries index zero
  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_kind_q == prs_pkg::KIND_IDLE) |-> (cur_idx_q == '0))
    else $error("idle context with non-zero index");

  // A result only follows a pass, which leaves something running
  a_kind_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_kind_q != prs_pkg::KIND_NONE))
    else $error("result with nothing running");

  // Idle results report slot zero
  a_idle_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && idle_chosen_o) |-> (chosen_slot_o == '0))
    else $error("idle result with non-zero slot");

endmodule

`default_nettype wire

// ----- test/tb_priority_ready_scheduler.sv -----
`timescale 1ns / 1ps

module tb_priority_ready_scheduler;

  localparam int NumSlots   = prs_pkg::NumSlotsDef;
  localparam int SettleCyc  = 30;    // settle time after the last pick, with margin over the longest pass
  localparam int QuietLimit = 4000;  // cycles with no beat on either channel
  localparam int PhaseItems = 143;
  localparam int HoldCyc    = 150;

  // Run state three has no name in the package; the block treats it as not ready
  localparam logic [prs_pkg::StateW-1:0] RS_OTHER = 2'd3;

  typedef struct packed {
    logic                       op;
    logic [prs_pkg::SlotW-1:0]  slot;
    logic [prs_pkg::InPrW-1:0]  prio;
    logic [prs_pkg::StateW-1:0] rs;
  } slot_cmd_t;

  typedef struct packed {
    logic [prs_pkg::SlotW-1:0] chosen;
    logic                      idle;
    logic                      switched;
  } pick_t;

  // Clock, reset and block inputs, all known from time zero
  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [prs_pkg::CountW-1:0] cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       operation = 1'b0;
  logic [prs_pkg::SlotW-1:0]  slot      = '0;
  logic [prs_pkg::InPrW-1:0]  prio      = '0;
  logic [prs_pkg::StateW-1:0] run_state = '0;
  logic                       out_stall = 1'b0;

  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [prs_pkg::SlotW-1:0]  chosen_slot_o;
  logic                       idle_chosen_o;
  logic                       switched_o;

  priority_ready_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .slot_i        (slot),
    .prio_value_i  (prio),
    .run_state_i   (run_state),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .chosen_slot_o (chosen_slot_o),
    .idle_chosen_o (idle_chosen_o),
    .switched_o    (switched_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the slot table and of what is running
  logic [prs_pkg::InPrW-1:0]  prio_tab  [NumSlots];
  logic [prs_pkg::StateW-1:0] state_tab [NumSlots];
  logic [prs_pkg::KindW-1:0]  cur_kind;
  logic [prs_pkg::SlotW-1:0]  cur_idx;
  logic [prs_pkg::CountW-1:0] run_count;

  slot_cmd_t pending_cmds [$];  // beats still to be offered
  pick_t     due_picks    [$];  // picks the block still owes
  slot_cmd_t cur_cmd;            // beat now on the input port

  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;
  int          drv_idle_pct = 30;
  int          rcv_idle_pct = 30;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_left    = 0;

  int unsigned phase_counts [10] = '{16, 1, 5, 0, 17, 9, 16, 2, 31, 12};

  task automatic clear_shadow();
    int k;
    for (k = 0; k < NumSlots; k++) begin
      prio_tab[k]  = '0;
      state_tab[k] = prs_pkg::RS_BLOCKED;
    end
    cur_kind  = prs_pkg::KIND_NONE;
    cur_idx   = '0;
    run_count = '0;
  endtask

  // Fold one accepted beat into the shadow; a scheduling pass owes one pick
  task automatic absorb_cmd(input slot_cmd_t c);
    int    lim;
    int    k;
    int    best;
    bit    found;
    pick_t p;
    if (c.op == prs_pkg::OP_WRITE) begin
      prio_tab[c.slot]  = c.prio;
      state_tab[c.slot] = c.rs;
    end else begin
      // a count above the table size covers the whole table
      lim   = (run_count > NumSlots) ? NumSlots : int'(run_count);
      found = 1'b0;
      best  = 0;
      for (k = 0; k < lim; k++) begin
        if (state_tab[k] == prs_pkg::RS_READY &&
            (!found || prio_tab[k] < prio_tab[best])) begin
          best  = k;
          found = 1'b1;
        end
      end
      if (found) begin
        if (cur_kind == prs_pkg::KIND_SLOT && cur_idx == prs_pkg::SlotW'(best)) begin
          // the running slot was rewritten as ready and wins again: keep it ready
          p.switched = 1'b0;
        end else begin
          // demote the old slot even when it lies outside the count
          if (cur_kind == prs_pkg::KIND_SLOT) state_tab[cur_idx] = prs_pkg::RS_READY;
          state_tab[best] = prs_pkg::RS_RUNNING;
          cur_kind   = prs_pkg::KIND_SLOT;
          cur_idx    = prs_pkg::SlotW'(best);
          p.switched = 1'b1;
        end
        p.chosen = prs_pkg::SlotW'(best);
        p.idle   = 1'b0;
      end else begin
        if (cur_kind == prs_pkg::KIND_IDLE) begin
          p.switched = 1'b0;
        end else begin
          if (cur_kind == prs_pkg::KIND_SLOT) state_tab[cur_idx] = prs_pkg::RS_READY;
          cur_kind   = prs_pkg::KIND_IDLE;
          cur_idx    = '0;
          p.switched = 1'b1;
        end
        p.chosen = '0;
        p.idle   = 1'b1;
      end
      due_picks.push_back(p);
    end
  endtask

  function automatic slot_cmd_t make_cmd(logic op, int unsigned s, int unsigned pv,
                                         logic [prs_pkg::StateW-1:0] rs);
    slot_cmd_t c;
    c.op   = op;
    c.slot = prs_pkg::SlotW'(s);
    c.prio = prs_pkg::InPrW'(pv);
    c.rs   = rs;
    return c;
  endfunction

  // Pick a slot mostly inside the count so that writes matter to the next pass
  function automatic int unsigned pick_slot(int lim);
    if (lim > 0 && $urandom_range(0, 9) < 7) return $urandom_range(0, lim - 1);
    return $urandom_range(0, NumSlots - 1);
  endfunction

  function automatic slot_cmd_t rand_write(int lim);
    int unsigned                r;
    int unsigned                pv;
    logic [prs_pkg::StateW-1:0] rs;
    // narrow priorities half the time so that ties turn up
    pv = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    r  = $urandom_range(0, 9);
    if (r < 5)      rs = prs_pkg::RS_READY;
    else if (r < 7) rs = prs_pkg::RS_RUNNING;
    else if (r < 9) rs = prs_pkg::RS_BLOCKED;
    else            rs = RS_OTHER;
    return make_cmd(prs_pkg::OP_WRITE, pick_slot(lim), pv, rs);
  endfunction

  function automatic slot_cmd_t rand_sched();
    // the unused payload fields still toggle
    return make_cmd(prs_pkg::OP_SCHED, $urandom_range(0, 15), $urandom_range(0, 255),
                    prs_pkg::StateW'($urandom_range(0, 3)));
  endfunction

  // Queue one short sequence of beats; return how many were queued
  task automatic queue_burst(input int lim, output int added);
    int unsigned kind;
    int unsigned n;
    int unsigned s;
    int          k;
    kind  = $urandom_range(0, 9);
    added = 0;
    if (kind <= 5) begin
      n = $urandom_range(0, 4);
      for (k = 0; k < n; k++) begin
        pending_cmds.push_back(rand_write(lim));
        added++;
      end
      pending_cmds.push_back(rand_sched());
      added++;
    end else if (kind == 6) begin
      // back-to-back passes with no write between them
      pending_cmds.push_back(rand_sched());
      pending_cmds.push_back(rand_sched());
      added = 2;
    end else if (kind == 7) begin
      // make a slot ready at top priority, pass, then mark it ready again (while it runs if the pass chose it)
      s = pick_slot(lim);
      pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, s, 0, prs_pkg::RS_READY));
      pending_cmds.push_back(rand_sched());
      pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, s, 0, prs_pkg::RS_READY));
      pending_cmds.push_back(rand_sched());
      added = 4;
    end else begin
      // stray write with any content
      pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, $urandom_range(0, 15),
                                      $urandom_range(0, 255),
                                      prs_pkg::StateW'($urandom_range(0, 3))));
      added = 1;
    end
  endtask

  // Wait until every beat is taken, every pick has come and the block is quiet
  task automatic drain_phase();
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk_i);
    while (due_picks.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic load_count(input int unsigned v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= prs_pkg::CountW'(v);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    run_count = prs_pkg::CountW'(v);
  endtask

  // Input driver: offer the next pending beat, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin : feed
    slot_cmd_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) absorb_cmd(cur_cmd);
      if (!in_valid || !in_stall_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= drv_idle_pct) begin
          nxt        = pending_cmds.pop_front();
          cur_cmd   <= nxt;
          in_valid  <= 1'b1;
          operation <= nxt.op;
          slot      <= nxt.slot;
          prio      <= nxt.prio;
          run_state <= nxt.rs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : sink
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left = HoldCyc;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest owed pick
  always @(posedge clk_i) begin : check
    pick_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: slot %0d idle %0b switched %0b",
                   chosen_slot_o, idle_chosen_o, switched_o);
      end else begin
        want = due_picks.pop_front();
        if (chosen_slot_o !== want.chosen || idle_chosen_o !== want.idle ||
            switched_o !== want.switched) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pick mismatch: slot %0d/%0d idle %0b/%0b switched %0b/%0b (exp/act)",
                     want.chosen, chosen_slot_o, want.idle, idle_chosen_o,
                     want.switched, switched_o);
        end
      end
    end
  end

  // Watchdog: drop out when neither channel moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
          $display("watchdog: no beat for %0d cycles", QuietLimit);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int ph;
    int got;
    int added;
    clear_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Count zero out of reset: no slot is scanned, idle runs once then stays
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 15, 255, RS_OTHER));
    drain_phase();

    // Full table: extremes, ties, not-ready states, the running slot made ready again
    load_count(16);
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 15, 255, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 0, 0, prs_pkg::RS_BLOCKED));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 3, 9, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 5, 9, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 1, 200, prs_pkg::RS_RUNNING));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 2, 0, RS_OTHER));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 3, 9, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 7, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 7, 0, prs_pkg::RS_BLOCKED));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 3, 9, prs_pkg::RS_BLOCKED));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 5, 9, prs_pkg::RS_BLOCKED));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    drain_phase();

    // Narrow count with slot 15 running: demote it from outside the count
    load_count(2);
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 0, 128, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    drain_phase();

    // Oversized count acts as the full table
    load_count(31);
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_WRITE, 15, 0, prs_pkg::RS_READY));
    pending_cmds.push_back(make_cmd(prs_pkg::OP_SCHED, 0, 0, prs_pkg::RS_READY));
    drain_phase();

    // Random phases, one count each
    for (ph = 0; ph < 10; ph++) begin
      load_count(phase_counts[ph]);
      if (ph == 2) begin
        // a stretch with no idling on either side
        drv_idle_pct <= 0;
        rcv_idle_pct <= 0;
      end else begin
        drv_idle_pct <= 30;
        rcv_idle_pct <= 30;
      end
      // long receiver hold-off so the output fills and the input stalls
      if (ph == 6) hold_req <= 1'b1;
      got = 0;
      while (got < PhaseItems) begin
        queue_burst((phase_counts[ph] > NumSlots) ? NumSlots : int'(phase_counts[ph]), added);
        got += added;
      end
      drain_phase();
    end

    if (mismatches == 0 && due_picks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
